@@ design/clsu_pkg.sv @@
// ----------------------------------------------------------------------------
// clsu_pkg
// Shared constants, types and helpers for the character display shadow
// updater: geometry, command bytes, operation codes and the image port bundle.
// ----------------------------------------------------------------------------
package clsu_pkg;

  localparam int ROWS   = 4;
  localparam int COLS   = 20;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = 5;
  localparam int ROW_W  = 2;

  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PUT   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef logic [ADDR_W-1:0] cell_addr_t;

  // Request bundle from the sequencer to the image store.
  typedef struct packed {
    cell_addr_t rd_addr;
    logic       wr_en;
    cell_addr_t wr_addr;
    logic [7:0] wr_data;
    logic       clr;
  } img_req_t;

  function automatic logic [7:0] row_offset(input logic [ROW_W-1:0] r);
    logic [7:0] off;
    case (r)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h14;
      2'd3:    off = 8'h54;
      default: off = 8'h00;
    endcase
    return off;
  endfunction

  function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] r);
    return (int'(r) >= ROWS) ? ROW_W'(ROWS - 1) : r;
  endfunction

  function automatic cell_addr_t cell_addr(input logic [ROW_W-1:0] r,
                                           input logic [COL_W-1:0] c);
    return ADDR_W'(int'(r) * COLS + int'(c));
  endfunction

  function automatic logic [7:0] addr_byte(input logic [COL_W-1:0] c,
                                           input logic [ROW_W-1:0] r);
    logic [7:0] sum;
    sum = 8'(c) + row_offset(r);
    return CMD_SET_ADDR | {1'b0, sum[6:0]};
  endfunction

endpackage

@@ design/char_lcd_shadow_update.sv @@
// ----------------------------------------------------------------------------
// char_lcd_shadow_update
// Shadow image of a character display that turns row loads, single puts and
// clears into the command and data bytes for the display controller.
// ----------------------------------------------------------------------------
// Results leave on strobe for exactly one cycle each and the receiver cannot
// stall them, so it must take every byte the cycle it shows. A transfer in
// is taken when start is high and busy is low. Every item reads its cell
// from the image memory at the transfer edge and compares it in the next
// cycle, while busy is high. A put that changes its cell sends three bytes.
// A row end with changes then sends a set-address byte and a data byte per
// column from the first to the last changed column, since the flush reads
// the image one cell per cycle. A clear sends only the clear command byte.
// Each byte appears on the ports in the cycle after the sequencer produces
// it; run_last marks the final byte of each transfer.
// ----------------------------------------------------------------------------
module char_lcd_shadow_update
  import clsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op,
  input  logic [1:0] row,
  input  logic [4:0] col,
  input  logic [7:0] char_code,
  input  logic       row_end,
  output logic       strobe,
  output logic       is_data,
  output logic [7:0] lcd_byte,
  output logic       run_last
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_PUT_DATA = 3'd2;
  localparam logic [2:0] S_PUT_ADDR = 3'd3;
  localparam logic [2:0] S_FL_ADDR  = 3'd4;
  localparam logic [2:0] S_FL_DATA  = 3'd5;

  logic [2:0]       state, state_next;

  // Held copy of the accepted transfer.
  logic [1:0]       op_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [7:0]       ch_q;
  logic             end_q;
  logic             col_ok_q;

  // Change tracking for the row being loaded.
  logic             any_chg, any_chg_next;
  logic [COL_W-1:0] first_chg, first_chg_next;
  logic [COL_W-1:0] last_chg, last_chg_next;

  // Flush walk.
  logic [COL_W-1:0] ptr, ptr_next;
  logic [COL_W-1:0] stop_col, stop_col_next;

  logic             out_stb_next, out_data_next, out_last_next;
  logic [7:0]       out_byte_next;

  img_req_t         req;
  logic [7:0]       cur_char;
  logic             changed;
  logic             accept;
  logic [ROW_W-1:0] in_row;
  logic             in_col_ok;

  clsu_image u_image (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (cur_char)
  );

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign in_row    = clamp_row(row);
  assign in_col_ok = (int'(col) < COLS);
  assign changed   = col_ok_q && (cur_char != ch_q);

  always_comb begin
    state_next     = state;
    any_chg_next   = any_chg;
    first_chg_next = first_chg;
    last_chg_next  = last_chg;
    ptr_next       = ptr;
    stop_col_next  = stop_col;
    out_stb_next   = 1'b0;
    out_data_next  = 1'b0;
    out_last_next  = 1'b0;
    out_byte_next  = addr_byte(col_q, row_q);
    req.rd_addr    = '0;
    req.wr_en      = 1'b0;
    req.wr_addr    = cell_addr(row_q, col_q);
    req.wr_data    = ch_q;
    req.clr        = 1'b0;

    case (state)
      S_IDLE: begin
        // Fetch the cell of the incoming transfer; compare next cycle.
        req.rd_addr = in_col_ok ? cell_addr(in_row, col) : '0;
        if (accept) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next = S_IDLE;
        case (op_q)
          OP_LOAD: begin
            req.wr_en = changed;
            if (changed) begin
              any_chg_next = 1'b1;
              if (!any_chg) begin
                first_chg_next = col_q;
                last_chg_next  = col_q;
              end else begin
                if (col_q < first_chg) first_chg_next = col_q;
                if (col_q > last_chg)  last_chg_next  = col_q;
              end
            end
            if (end_q) begin
              // Hand the span to the flush walk and restart tracking.
              ptr_next       = first_chg_next;
              stop_col_next  = last_chg_next;
              if (any_chg_next) begin
                state_next = S_FL_ADDR;
              end
              any_chg_next   = 1'b0;
              first_chg_next = '0;
              last_chg_next  = '0;
            end
          end
          OP_PUT: begin
            req.wr_en    = changed;
            out_stb_next = 1'b1;
            if (changed) begin
              state_next = S_PUT_DATA;
            end else begin
              out_last_next = 1'b1;
            end
          end
          OP_CLEAR: begin
            req.clr        = 1'b1;
            any_chg_next   = 1'b0;
            first_chg_next = '0;
            last_chg_next  = '0;
            out_stb_next   = 1'b1;
            out_last_next  = 1'b1;
            out_byte_next  = CMD_CLEAR;
          end
          default: begin
          end
        endcase
      end

      S_PUT_DATA: begin
        out_stb_next  = 1'b1;
        out_data_next = 1'b1;
        out_byte_next = ch_q;
        state_next    = S_PUT_ADDR;
      end

      S_PUT_ADDR: begin
        out_stb_next  = 1'b1;
        out_last_next = 1'b1;
        state_next    = S_IDLE;
      end

      S_FL_ADDR: begin
        // Emit set-address and fetch the first changed cell.
        out_stb_next  = 1'b1;
        out_byte_next = addr_byte(ptr, row_q);
        req.rd_addr   = cell_addr(row_q, ptr);
        state_next    = S_FL_DATA;
      end

      S_FL_DATA: begin
        out_stb_next  = 1'b1;
        out_data_next = 1'b1;
        out_byte_next = cur_char;
        if (ptr == stop_col) begin
          out_last_next = 1'b1;
          state_next    = S_IDLE;
        end else begin
          ptr_next    = ptr + 1'b1;
          req.rd_addr = cell_addr(row_q, ptr + 1'b1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      any_chg   <= 1'b0;
      first_chg <= '0;
      last_chg  <= '0;
      strobe    <= 1'b0;
    end else begin
      state     <= state_next;
      any_chg   <= any_chg_next;
      first_chg <= first_chg_next;
      last_chg  <= last_chg_next;
      strobe    <= out_stb_next;
    end
  end

  // Payload: hold the transfer, walk pointers and the output byte.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= op;
      row_q    <= in_row;
      col_q    <= col;
      ch_q     <= char_code;
      end_q    <= row_end;
      col_ok_q <= in_col_ok;
    end
    ptr      <= ptr_next;
    stop_col <= stop_col_next;
    is_data  <= out_data_next;
    lcd_byte <= out_byte_next;
    run_last <= out_last_next;
  end

endmodule

@@ design/clsu_image.sv @@
// ----------------------------------------------------------------------------
// clsu_image
// Shadow image store: one synchronous memory with a registered read port and
// per-cell valid bits; a cell that is not valid reads as a space.
// ----------------------------------------------------------------------------
module clsu_image
  import clsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  img_req_t   req,
  output logic [7:0] rd_data
);

  logic [7:0]       mem [CELLS];
  logic [CELLS-1:0] valid;
  logic [7:0]       rd_raw;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_raw   <= mem[req.rd_addr];
    rd_valid <= valid[req.rd_addr];
  end

  // Drop every cell back to space at once on reset or clear.
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_valid ? rd_raw : SPACE_CHAR;

endmodule
